/* rtl/tagged_frame_allocator_top_assert.svh */
// Assertion macros used by the frame allocator sequencer (tfa_ctrl).
`ifndef TAGGED_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define TAGGED_FRAME_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define TFA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TFA_ASSERT_IMPL(lbl, ante, cons, msg)
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/tfa_pkg.sv */
// Shared types and constants of the frame allocator.
package tfa_pkg;
	localparam int unsigned MAX_FRAMES_DEF = 4096;

	localparam int unsigned COUNT_W    = 13;
	localparam int unsigned TAG_W      = 8;
	localparam int unsigned IDX_W      = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 13'd4096;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START  = 2'd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_REQ  = 2'd1,
		ST_LOW_FREE = 2'd2,
		ST_NO_RUN   = 2'd3
	} tfa_status_t;

	typedef struct packed {
		tfa_status_t        status;
		logic [IDX_W-1:0]   run_start;
		logic [COUNT_W-1:0] free_frames;
	} tfa_result_t;
endpackage

/* rtl/tagged_frame_allocator_top.sv */
// Frame allocator top level: configuration registers, output register, core.
// Allocate: accept, scan of one tag per cycle from search_start, then one write
//   per allocated frame, then the result is offered.
// Free: one write per freed frame; rejected requests go straight to the result.
// One request is in flight at a time; the output register frees the input side.
// After arst_n the tag memory is swept to free, with in_stall high.
module tagged_frame_allocator_top #(
	parameter int unsigned MAX_FRAMES = tfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [tfa_pkg::COUNT_W-1:0]       frame_count,
	input  logic [tfa_pkg::TAG_W-1:0]         owner_tag,
	input  logic [tfa_pkg::IDX_W-1:0]         first_frame,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [tfa_pkg::IDX_W-1:0]         run_start,
	output logic [tfa_pkg::COUNT_W-1:0]       free_frames,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tfa_pkg::*;

	localparam int unsigned AW = $clog2(MAX_FRAMES);

	logic [COUNT_W-1:0] frames_in_use_q;
	logic [IDX_W-1:0]   search_start_q;
	logic               out_valid_q;
	tfa_result_t        out_q;
	tfa_result_t        res;
	logic               res_valid;
	logic               res_ready;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [TAG_W-1:0]   mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [TAG_W-1:0]   mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
			search_start_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAMES_IN_USE: frames_in_use_q <= cfg_data;
				REG_SEARCH_START:  search_start_q  <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register: a waiting result does not hold off the next request
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign run_start   = out_q.run_start;
	assign free_frames = out_q.free_frames;

	tfa_ctrl #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.frame_count   (frame_count),
		.owner_tag     (owner_tag),
		.first_frame   (first_frame),
		.frames_in_use (frames_in_use_q),
		.search_start  (search_start_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data)
	);

	tfa_tag_mem #(
		.DEPTH (MAX_FRAMES),
		.AW    (AW)
	) u_tag_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);
endmodule

/* rtl/tfa_tag_mem.sv */
// Owner tag memory: one write port, one read port, registered read data.
module tfa_tag_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [tfa_pkg::TAG_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [tfa_pkg::TAG_W-1:0] rd_data
);
	import tfa_pkg::*;

	logic [TAG_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* rtl/tfa_ctrl.sv */
// Request sequencer: clearing pass, first-fit scan, run write and free count.
module tfa_ctrl #(
	parameter int unsigned MAX_FRAMES = tfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [tfa_pkg::COUNT_W-1:0]         frame_count,
	input  logic [tfa_pkg::TAG_W-1:0]           owner_tag,
	input  logic [tfa_pkg::IDX_W-1:0]           first_frame,
	input  logic [tfa_pkg::COUNT_W-1:0]         frames_in_use,
	input  logic [tfa_pkg::IDX_W-1:0]           search_start,
	output logic                                res_valid,
	input  logic                                res_ready,
	output tfa_pkg::tfa_result_t                res,
	output logic                                mem_wr_en,
	output logic [$clog2(MAX_FRAMES)-1:0]       mem_wr_addr,
	output logic [tfa_pkg::TAG_W-1:0]           mem_wr_data,
	output logic                                mem_rd_en,
	output logic [$clog2(MAX_FRAMES)-1:0]       mem_rd_addr,
	input  logic [tfa_pkg::TAG_W-1:0]           mem_rd_data
);
	import tfa_pkg::*;

	localparam int unsigned AW = $clog2(MAX_FRAMES);
	localparam int unsigned NW = $clog2(MAX_FRAMES + 1);
	localparam int unsigned IW = (NW > 14) ? NW : 14;
	localparam logic [IW-1:0] MAX_C = IW'(MAX_FRAMES);
	localparam logic [COUNT_W-1:0] FREE_RST =
		(MAX_FRAMES < 4096) ? COUNT_W'(MAX_FRAMES) : 13'd4096;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_WRITE = 5'b01000,
		S_RESP  = 5'b10000
	} tfa_state_t;

	tfa_state_t         state_q;
	logic [IW-1:0]      ptr_q;
	logic [IW-1:0]      wr_end_q;
	logic [IW-1:0]      freed_q;
	logic [IW-1:0]      start_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] run_len_q;
	logic [COUNT_W-1:0] free_total_q;
	logic [TAG_W-1:0]   tag_q;
	logic               op_q;
	tfa_status_t        status_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      addr_s1;

	logic [IW-1:0]      n_c;
	logic [IW-1:0]      fiu_ext;
	logic [IW-1:0]      first_ext;
	logic [IW-1:0]      cnt_ext;
	logic [IW-1:0]      cntq_ext;
	logic [IW-1:0]      end_sum;
	logic [IW-1:0]      end_c;
	logic [IW-1:0]      free_ext;
	logic [IW-1:0]      free_sum;
	logic [IW-1:0]      free_next;
	logic               accept;
	logic               hit;
	logic               wr_last;

	// effective table size
	assign fiu_ext   = {{(IW-COUNT_W){1'b0}}, frames_in_use};
	assign n_c       = (fiu_ext < MAX_C) ? fiu_ext : MAX_C;
	assign first_ext = {{(IW-IDX_W){1'b0}}, first_frame};
	assign cnt_ext   = {{(IW-COUNT_W){1'b0}}, frame_count};
	assign cntq_ext  = {{(IW-COUNT_W){1'b0}}, count_q};
	assign end_sum   = first_ext + cnt_ext;
	assign end_c     = (end_sum > n_c) ? n_c : end_sum;

	// free count saturates at the table size and never rises while at or above it
	assign free_ext  = {{(IW-COUNT_W){1'b0}}, free_total_q};
	assign free_sum  = free_ext + freed_q;
	assign free_next = (free_ext >= n_c) ? free_ext : ((free_sum > n_c) ? n_c : free_sum);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	assign mem_rd_en   = (state_q == S_SCAN) && (ptr_q < n_c);
	assign mem_rd_addr = ptr_q[AW-1:0];
	assign mem_wr_en   = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign mem_wr_addr = ptr_q[AW-1:0];
	assign mem_wr_data = (state_q == S_CLEAR) ? '0 : tag_q;

	assign hit = (state_q == S_SCAN) && rd_vld_s1 && (mem_rd_data == '0) &&
		((run_len_q + 1'b1) == count_q);
	assign wr_last = (ptr_q == wr_end_q);

	assign res_valid       = (state_q == S_RESP);
	assign res.status      = status_q;
	assign res.run_start   = start_q[IDX_W-1:0];
	assign res.free_frames = free_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			free_total_q <= FREE_RST;
		end else begin
			rd_vld_s1 <= mem_rd_en && !hit;
			addr_s1   <= ptr_q;
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == MAX_C - 1'b1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= opcode;
						count_q <= frame_count;
						start_q <= '0;
						if (opcode == OP_ALLOC) begin
							tag_q <= owner_tag;
							if (frame_count == '0 || owner_tag == '0) begin
								status_q <= ST_BAD_REQ;
								state_q  <= S_RESP;
							end else if (free_total_q < frame_count) begin
								status_q <= ST_LOW_FREE;
								state_q  <= S_RESP;
							end else begin
								status_q  <= ST_NO_RUN;
								ptr_q     <= {{(IW-IDX_W){1'b0}}, search_start};
								run_len_q <= '0;
								state_q   <= S_SCAN;
							end
						end else begin
							tag_q <= '0;
							if (frame_count == '0 || first_ext >= n_c) begin
								status_q <= ST_BAD_REQ;
								state_q  <= S_RESP;
							end else begin
								status_q <= ST_OK;
								ptr_q    <= first_ext;
								wr_end_q <= end_c - 1'b1;
								freed_q  <= end_c - first_ext;
								state_q  <= S_WRITE;
							end
						end
					end
				end
				S_SCAN: begin
					if (mem_rd_en && !hit) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (mem_rd_data != '0) begin
							run_len_q <= '0;
						end else if (hit) begin
							// run ends at the frame just read; rewind to its first frame
							start_q      <= addr_s1 + 1'b1 - cntq_ext;
							ptr_q        <= addr_s1 + 1'b1 - cntq_ext;
							wr_end_q     <= addr_s1;
							free_total_q <= free_total_q - count_q;
							status_q     <= ST_OK;
							state_q      <= S_WRITE;
						end else begin
							run_len_q <= run_len_q + 1'b1;
						end
					end else if (!mem_rd_en) begin
						state_q <= S_RESP;
					end
				end
				S_WRITE: begin
					ptr_q <= ptr_q + 1'b1;
					if (wr_last) begin
						if (op_q == OP_FREE) begin
							free_total_q <= free_next[COUNT_W-1:0];
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "tagged_frame_allocator_top_assert.svh"

	`TFA_ASSERT_IMPL(a_no_rw_overlap, mem_wr_en, !mem_rd_en, "tag read during a write pass")
	`TFA_ASSERT_IMPL(a_run_len_bound, state_q == S_SCAN, run_len_q < count_q, "run length overran")
	`TFA_ASSERT_IMPL(a_wr_in_range, state_q == S_WRITE, ptr_q < n_c, "write past table end")
	`TFA_ASSERT_NEXT(a_resp_hold, state_q == S_RESP && !res_ready, state_q == S_RESP, "result lost")
endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the tagged frame allocator: directed table, random phases.
module testbench;
	import tfa_pkg::*;

	localparam int unsigned MAX_FRAMES  = MAX_FRAMES_DEF;
	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned TAIL_CYCLES = 100;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd2;

	typedef struct packed {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		logic                 op;
		logic [COUNT_W-1:0]   count;
		logic [TAG_W-1:0]     tag;
		logic [IDX_W-1:0]     first;
		bit                   typed;
		tfa_result_t          want;
	} plan_row_t;

	typedef struct packed {
		logic [IDX_W-1:0]   start;
		logic [COUNT_W-1:0] len;
	} run_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  opcode;
	logic [COUNT_W-1:0]    frame_count;
	logic [TAG_W-1:0]      owner_tag;
	logic [IDX_W-1:0]      first_frame;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [IDX_W-1:0]      run_start;
	logic [COUNT_W-1:0]    free_frames;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// allocator state as predicted
	logic [TAG_W-1:0] frame_owner [MAX_FRAMES];
	int unsigned      free_count;
	int unsigned      managed_frames;
	int unsigned      scan_origin;

	tfa_result_t owed_results [$];
	run_t        live_runs [$];
	plan_row_t   plan [$];
	int unsigned phase_sizes [$] = '{4096, 64, 16, 200, 1, 4096, 37};

	bit          item_has_want;
	tfa_result_t item_want;
	bit          tx_eager;
	bit          rx_eager;
	bit          long_hold_req;
	int unsigned errors;
	int unsigned results_seen;
	int unsigned cycle_count;

	tagged_frame_allocator_top #(
		.MAX_FRAMES(MAX_FRAMES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.frame_count(frame_count),
		.owner_tag(owner_tag),
		.first_frame(first_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.run_start(run_start),
		.free_frames(free_frames),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycle_count,
				owed_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// first-fit allocate / free, updates the predicted state
	function automatic tfa_result_t predict_request(input logic op,
		input logic [COUNT_W-1:0] count, input logic [TAG_W-1:0] tag,
		input logic [IDX_W-1:0] first);
		tfa_result_t res;
		int unsigned n, i, j, stop;
		run_t run;
		n = (managed_frames < MAX_FRAMES) ? managed_frames : MAX_FRAMES;
		res.status = ST_OK;
		res.run_start = '0;
		if (op == OP_ALLOC) begin
			if (count == 0 || tag == 0) begin
				res.status = ST_BAD_REQ;
			end else if (free_count < count) begin
				res.status = ST_LOW_FREE;
			end else begin
				res.status = ST_NO_RUN;
				i = scan_origin;
				while (i < n) begin
					if (frame_owner[i] == 0) begin
						j = 0;
						while (j < count && i + j < n && frame_owner[i + j] == 0)
							j++;
						if (j == count) begin
							for (j = 0; j < count; j++)
								frame_owner[i + j] = tag;
							free_count -= count;
							res.run_start = i[IDX_W-1:0];
							res.status = ST_OK;
							run.start = i[IDX_W-1:0];
							run.len = count;
							live_runs.push_back(run);
							break;
						end
						// resume past the frame that broke the run
						i += j;
					end
					i++;
				end
			end
		end else begin
			if (count == 0 || first >= n) begin
				res.status = ST_BAD_REQ;
			end else begin
				stop = first + count;
				if (stop > n)
					stop = n;
				for (i = first; i < stop; i++) begin
					frame_owner[i] = '0;
					if (free_count < n)
						free_count++;
				end
			end
		end
		res.free_frames = free_count[COUNT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d, want %0d", results_seen, what, got,
			want);
		errors++;
	endtask

	// request transfer: predict, or take the typed expectation
	always @(posedge clk) begin
		tfa_result_t predicted;
		if (arst_n && in_valid && !in_stall) begin
			predicted = predict_request(opcode, frame_count, owner_tag, first_frame);
			owed_results.push_back(item_has_want ? item_want : predicted);
		end
	end

	// result transfer: compare with the oldest owed result
	always @(posedge clk) begin
		tfa_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, -1);
			end else begin
				want = owed_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (run_start !== want.run_start)
					report_mismatch("run_start", run_start, want.run_start);
				if (free_frames !== want.free_frames)
					report_mismatch("free_frames", free_frames, want.free_frames);
			end
			results_seen++;
		end
	end

	// result side stall pattern
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		rx_eager = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
			end
			if ($urandom_range(0, 15) == 0)
				rx_eager = !rx_eager;
			hold = rx_eager ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	task automatic send_request(input logic op, input logic [COUNT_W-1:0] count,
		input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] first, input bit typed,
		input tfa_result_t want);
		int unsigned gap;
		gap = tx_eager ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode = op;
		frame_count = count;
		owner_tag = tag;
		first_frame = first;
		item_has_want = typed;
		item_want = want;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// lower valid and wait until every owed result has come back
	task automatic wait_idle();
		in_valid = 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_FRAMES_IN_USE)
			managed_frames = data;
		else if (idx == REG_SEARCH_START)
			scan_origin = data[IDX_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = data;
		plan.push_back(r);
	endtask

	task automatic row_req(input logic op, input int count, input int tag, input int first,
		input bit typed = 1'b0, input tfa_status_t st = ST_OK, input int start = 0,
		input int free = 0);
		plan_row_t r;
		r = '0;
		r.op = op;
		r.count = COUNT_W'(count);
		r.tag = TAG_W'(tag);
		r.first = IDX_W'(first);
		r.typed = typed;
		r.want.status = st;
		r.want.run_start = IDX_W'(start);
		r.want.free_frames = COUNT_W'(free);
		plan.push_back(r);
	endtask

	initial begin
		tfa_result_t none;
		run_t run;
		int unsigned sz, pick, roll, span;
		logic op;
		logic [COUNT_W-1:0] count;
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] first;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		frame_count = '0;
		owner_tag = '0;
		first_frame = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAMES_IN_USE;
		cfg_data = '0;
		item_has_want = 1'b0;
		item_want = '0;
		tx_eager = 1'b0;
		long_hold_req = 1'b0;
		none = '0;
		for (int k = 0; k < MAX_FRAMES; k++)
			frame_owner[k] = '0;
		managed_frames = FRAMES_IN_USE_RST;
		scan_origin = 0;
		free_count = MAX_FRAMES;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero count / zero tag, whole table, too few free
		row_req(OP_ALLOC, 0, 8'h05, 0, 1, ST_BAD_REQ, 0, 4096);
		row_req(OP_ALLOC, 3, 8'h00, 0, 1, ST_BAD_REQ, 0, 4096);
		row_req(OP_ALLOC, 1, 8'hFF, 0, 1, ST_OK, 0, 4095);
		row_req(OP_ALLOC, 4096, 8'h01, 0, 1, ST_LOW_FREE, 0, 4095);
		row_req(OP_ALLOC, 4095, 8'h80, 0, 1, ST_OK, 1, 0);
		row_req(OP_ALLOC, 1, 8'h01, 0, 1, ST_LOW_FREE, 0, 0);
		// free: zero count, crossing the end, saturation, already free
		row_req(OP_FREE, 0, 8'h00, 5, 1, ST_BAD_REQ, 0, 0);
		row_req(OP_FREE, 4096, 8'h00, 4095, 1, ST_OK, 0, 1);
		row_req(OP_FREE, 4096, 8'h00, 0, 1, ST_OK, 0, 4096);
		row_req(OP_FREE, 2, 8'h00, 10, 1, ST_OK, 0, 4096);
		// run may not cross the table end
		row_cfg(REG_SEARCH_START, 4095);
		row_req(OP_ALLOC, 2, 8'h07, 0, 1, ST_NO_RUN, 0, 4096);
		row_req(OP_ALLOC, 1, 8'h07, 0, 1, ST_OK, 4095, 4095);
		// one-frame table, search start past it, counter above table size
		row_cfg(REG_FRAMES_IN_USE, 1);
		row_req(OP_ALLOC, 1, 8'h03, 0, 1, ST_NO_RUN, 0, 4095);
		row_req(OP_FREE, 1, 8'h00, 1, 1, ST_BAD_REQ, 0, 4095);
		row_req(OP_FREE, 1, 8'h00, 0, 1, ST_OK, 0, 4095);
		row_cfg(REG_SEARCH_START, 0);
		row_req(OP_ALLOC, 1, 8'hAA, 0, 1, ST_OK, 0, 4094);
		row_req(OP_ALLOC, 1, 8'h55, 0, 1, ST_NO_RUN, 0, 4094);
		row_req(OP_FREE, 1, 8'h00, 0, 1, ST_OK, 0, 4094);
		row_req(OP_ALLOC, 2, 8'h55, 0, 1, ST_NO_RUN, 0, 4094);
		// unknown register index is dropped
		row_cfg(REG_RESERVED, 5);
		row_cfg(REG_FRAMES_IN_USE, 4096);
		row_req(OP_FREE, 4096, 8'h00, 0, 1, ST_OK, 0, 4096);
		// fragmentation: scan skips past the frame that broke the run
		row_req(OP_ALLOC, 4, 8'h11, 0);
		row_req(OP_ALLOC, 4, 8'h22, 0);
		row_req(OP_FREE, 2, 8'h00, 0);
		row_req(OP_ALLOC, 3, 8'h33, 0);
		row_req(OP_ALLOC, 4096, 8'hFF, 0);

		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				wait_idle();
				write_reg(plan[r].cfg_idx, plan[r].cfg_val);
			end else begin
				send_request(plan[r].op, plan[r].count, plan[r].tag, plan[r].first,
					plan[r].typed, plan[r].want);
			end
		end

		foreach (phase_sizes[p]) begin
			wait_idle();
			sz = phase_sizes[p];
			write_reg(REG_FRAMES_IN_USE, CFG_DATA_W'(sz));
			if (sz < MAX_FRAMES && $urandom_range(0, 4) == 0)
				write_reg(REG_SEARCH_START,
					CFG_DATA_W'($urandom_range(sz, MAX_FRAMES - 1)));
			else
				write_reg(REG_SEARCH_START, CFG_DATA_W'($urandom_range(0, (sz - 1) / 2)));
			live_runs.delete();
			tx_eager = (p % 3 == 2);
			if (p == 1)
				long_hold_req = 1'b1;
			span = (sz / 4 > 1) ? sz / 4 : 1;
			for (int n = 0; n < 16; n++) begin
				if (p == 3 && n == 10)
					wait_idle();
				if ($urandom_range(0, 15) == 0)
					tx_eager = !tx_eager;
				roll = $urandom_range(0, 99);
				op = OP_ALLOC;
				count = COUNT_W'($urandom_range(1, span));
				tag = TAG_W'($urandom_range(1, 255));
				first = IDX_W'($urandom_range(0, MAX_FRAMES - 1));
				if (roll >= 50 && roll < 85) begin
					op = OP_FREE;
					if (live_runs.size() != 0) begin
						pick = $urandom_range(0, live_runs.size() - 1);
						run = live_runs[pick];
						live_runs.delete(pick);
						first = run.start;
						count = run.len;
						if ($urandom_range(0, 3) == 0)
							count = count + COUNT_W'($urandom_range(0, 8));
					end else begin
						first = IDX_W'($urandom_range(0, sz - 1));
					end
				end else if (roll >= 85) begin
					// malformed or oversized requests
					op = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 3))
						0: count = '0;
						1: tag = '0;
						2: count = COUNT_W'($urandom_range(0, 4096));
						default: count = 4096;
					endcase
				end
				send_request(op, count, tag, first, 1'b0, none);
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/tfa_pkg.sv
rtl/tfa_tag_mem.sv
rtl/tfa_ctrl.sv
rtl/tagged_frame_allocator_top.sv
dv/testbench.sv
